>>> rtl/kmp_pkg.sv
package kmp_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 4'd2;

    // Hard limit on the pattern bytes held in the configuration registers.
    localparam int unsigned PATTERN_BYTES = 16;

    // One text word from the input channel.
    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } text_word_t;

    // One result word on the output channel.
    typedef struct packed {
        logic        match_found;
        logic [31:0] match_start;
        logic        text_done;
    } result_word_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

endpackage

>>> rtl/kmp_stream_matcher.sv
// Channel    Handshake             Payload
// text       text_valid/stall      text_word   (text_char, end_of_text)
// result     result_valid/stall    result_word (match_found, match_start, text_done)
// cfg        cfg_valid/ready       cfg_index, cfg_data
//
// One text word per cycle while the text side does not stall; its result
// appears in the output register on the next cycle. Every cell of the
// compare row evaluates in the same cycle, so only the output register holds the result.
// Reset clears the row, the position and the output valid; the pattern
// resets to all zeros with length one. The text side stalls only while a
// result waits in the output register and the result side stalls.
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int unsigned MAX_PATTERN   = 16,
    parameter int unsigned POSITION_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_stall,
    input  text_word_t                text_word,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_word_t              result_word,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [63:0]               cfg_data
);

    // Number of cells that can ever hold a live prefix.
    localparam int unsigned NCELL    =
        (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int unsigned IDX_BITS = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [4:0]  LEN_LIM  = 5'(NCELL);

    logic [63:0]              pattern_low_reg;
    logic [63:0]              pattern_high_reg;
    logic [4:0]               pattern_length_reg;
    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    logic                     result_valid_reg;
    result_word_t             result_word_reg;

    logic                     cfg_write;
    logic                     cfg_hit;
    logic                     text_accept;
    logic [4:0]               len_eff;
    logic [4:0]               len_m1;
    logic [127:0]             pattern_all;
    logic [NCELL-1:0]         cell_hit;
    logic [NCELL-1:0]         cell_match;
    logic                     found;
    logic [POSITION_BITS-1:0] start_pos;
    logic [63:0]              start_wide;
    cell_ctrl_t               ctrl;

    // Handshakes.
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign cfg_hit     = cfg_write && ((cfg_index == CFG_PATTERN_LOW) ||
                                       (cfg_index == CFG_PATTERN_HIGH) ||
                                       (cfg_index == CFG_PATTERN_LENGTH));
    assign text_stall  = result_valid_reg && result_stall;
    assign text_accept = text_valid && !text_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= 64'd0;
            pattern_high_reg   <= 64'd0;
            pattern_length_reg <= 5'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // Length in use: zero counts as one, large values saturate.
    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            len_eff = 5'd1;
        end
        else if (pattern_length_reg > LEN_LIM)
        begin
            len_eff = LEN_LIM;
        end
        else
        begin
            len_eff = pattern_length_reg;
        end
    end

    assign len_m1      = len_eff - 5'd1;
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // A write to a decoded configuration register or the last byte of a text empties the row.
    assign ctrl = '{advance: text_accept,
                    flush:   cfg_hit || (text_accept && text_word.end_of_text)};

    // Compare row: cell j tracks a match of the first j+1 pattern bytes.
    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        logic prev;
        logic en;

        if (j == 0)
        begin : g_first
            assign prev = 1'b1;
        end
        else
        begin : g_rest
            assign prev = cell_match[j-1];
        end

        assign en = (5'(j) < len_eff);

        kmp_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .cell_enable  (en),
            .pattern_char (pattern_all[8*j +: 8]),
            .text_char    (text_word.text_char),
            .prev_match   (prev),
            .hit          (cell_hit[j]),
            .match        (cell_match[j])
        );
    end

    // An occurrence ends here when the cell of the full length hits.
    assign found      = cell_hit[len_m1[IDX_BITS-1:0]];
    assign start_pos  = position_reg - POSITION_BITS'(len_m1);
    assign start_wide = 64'(start_pos);

    // Text position advances per word and restarts after end of text.
    always_comb
    begin
        position_next = position_reg;
        if (text_accept)
        begin
            if (text_word.end_of_text)
            begin
                position_next = '0;
            end
            else
            begin
                position_next = position_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (text_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            result_word_reg.match_found <= found;
            result_word_reg.match_start <= found ? start_wide[31:0] : 32'd0;
            result_word_reg.text_done   <= text_word.end_of_text;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

endmodule

>>> rtl/kmp_cell.sv
module kmp_cell
    import kmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       cell_enable,
    input  logic [7:0] pattern_char,
    input  logic [7:0] text_char,
    input  logic       prev_match,
    output logic       hit,
    output logic       match
);

    logic match_reg;
    logic match_next;

    // The prefix that ends at this cell matches when the shorter prefix
    // matched at the previous byte and this cell's pattern byte equals the
    // incoming byte.
    assign hit = prev_match && cell_enable && (pattern_char == text_char);

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.flush)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            match_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

>>> sim/tb.sv
module tb;
    import kmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The first register index that decodes to nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = CFG_PATTERN_LENGTH + 1'b1;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    logic                      clk;
    logic                      rst_n;
    logic                      text_valid;
    logic                      text_stall;
    text_word_t                text_word;
    logic                      result_valid;
    logic                      result_stall;
    result_word_t              result_word;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [63:0]               cfg_data;

    // Predictor state: register copies, derived pattern and the matcher progress.
    logic [63:0]       reg_pattern_low;
    logic [63:0]       reg_pattern_high;
    logic [4:0]        reg_pattern_len;
    logic [7:0]        pat_byte [PATTERN_BYTES];
    logic [4:0]        border [PATTERN_BYTES];
    int unsigned       pat_len;
    logic [4:0]        progress;
    logic [31:0]       position;

    result_word_t      predicted_results [$];
    int unsigned       error_count;
    bit                send_calm;
    bit                recv_calm;
    bit                hold_request;

    kmp_stream_matcher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_word    (text_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rebuild the border table from the register copies and drop any partial match.
    function automatic void derive_borders();
        int i;
        int k;
        if (reg_pattern_len == 0)
            pat_len = 1;
        else if (reg_pattern_len > PATTERN_BYTES)
            pat_len = PATTERN_BYTES;
        else
            pat_len = 32'(reg_pattern_len);
        for (i = 0; i < PATTERN_BYTES; i++)
        begin
            if (i < 8)
                pat_byte[i] = reg_pattern_low[8*i +: 8];
            else
                pat_byte[i] = reg_pattern_high[8*(i-8) +: 8];
            border[i] = '0;
        end
        k = 0;
        for (i = 1; i < pat_len; i++)
        begin
            while (k > 0 && pat_byte[k] != pat_byte[i])
                k = int'(border[k-1]);
            if (pat_byte[k] == pat_byte[i])
                k++;
            border[i] = k[4:0];
        end
        progress = '0;
    endfunction

    function automatic void reset_matcher();
        reg_pattern_low  = '0;
        reg_pattern_high = '0;
        reg_pattern_len  = 5'd1;
        position         = '0;
        derive_borders();
    endfunction

    // An index that decodes to no register leaves everything alone.
    function automatic void apply_register(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
        case (idx)
            CFG_PATTERN_LOW:    reg_pattern_low  = data;
            CFG_PATTERN_HIGH:   reg_pattern_high = data;
            CFG_PATTERN_LENGTH: reg_pattern_len  = data[4:0];
            default:            return;
        endcase
        derive_borders();
    endfunction

    // Advance the partial match by one text byte and report a completed occurrence.
    function automatic result_word_t predict_match(text_word_t w);
        result_word_t r;
        int q;
        r = '0;
        q = int'(progress);
        if (q >= pat_len)
            q = 0;
        while (q > 0 && pat_byte[q] != w.text_char)
            q = int'(border[q-1]);
        if (pat_byte[q] == w.text_char)
            q++;
        if (q == pat_len)
        begin
            r.match_found = 1'b1;
            r.match_start = position - (pat_len - 1);
            q = int'(border[pat_len-1]);
        end
        progress = q[4:0];
        position = position + 1'b1;
        r.text_done = w.end_of_text;
        if (w.end_of_text)
        begin
            progress = '0;
            position = '0;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
        error_count++;
    endtask

    // Predict every accepted text word, then check every accepted result word.
    always @(posedge clk)
    begin : check_results
        result_word_t want;
        if (rst_n && text_valid && !text_stall)
            predicted_results = {predicted_results, predict_match(text_word)};
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("result word with nothing expected", 64'(result_word), '0);
            else
            begin
                want = predicted_results.pop_front();
                if (result_word.match_found !== want.match_found)
                    report_mismatch("match_found", 64'(result_word.match_found),
                                    64'(want.match_found));
                if (result_word.match_start !== want.match_start)
                    report_mismatch("match_start", 64'(result_word.match_start),
                                    64'(want.match_start));
                if (result_word.text_done !== want.text_done)
                    report_mismatch("text_done", 64'(result_word.text_done),
                                    64'(want.text_done));
            end
        end
    end

    // Result side: random stall runs, or one long hold when a test asks for it.
    initial
    begin : result_side
        int unsigned run;
        run = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                run = LONG_HOLD - 1;
                result_stall <= 1'b1;
            end
            else if (run > 0)
                run--;
            else
            begin
                run = recv_calm ? 0 : pick_gap();
                result_stall <= !recv_calm && ($urandom_range(0, 99) < 35);
            end
        end
    end

    // End the run when no word moves on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Offer one text word, hold it until accepted, then idle for a random gap unless send_calm is set.
    task automatic send_text(logic [7:0] ch, logic eot);
        text_word_t w;
        int unsigned idle;
        w.text_char   = ch;
        w.end_of_text = eot;
        @(negedge clk);
        text_valid <= 1'b1;
        text_word  <= w;
        do @(posedge clk); while (text_stall);
        idle = send_calm ? 0 : pick_gap();
        if (idle > 0)
        begin
            @(negedge clk);
            text_valid <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering text and wait until every predicted result word has come back.
    task automatic settle();
        @(negedge clk);
        text_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The reset pattern is a single zero byte.
    task automatic test_reset_pattern();
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);
        settle();
    endtask

    // Overlapping occurrences; a write to an unused index must keep the partial match.
    task automatic test_overlap();
        write_reg(CFG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_00FF);
        write_reg(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        settle();
        write_reg(CFG_UNUSED, 64'h0123_4567_89AB_CDEF);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        settle();
    endtask

    // Length zero reads as one, lengths above sixteen saturate.
    task automatic test_length_limits();
        logic [63:0] low;
        logic [63:0] high;
        int i;
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
        write_reg(CFG_PATTERN_LOW, low);
        write_reg(CFG_PATTERN_LENGTH, 64'h0);
        send_text(low[7:0], 1'b0);
        settle();
        write_reg(CFG_PATTERN_HIGH, high);
        write_reg(CFG_PATTERN_LENGTH, 64'h1F);
        for (i = 0; i < 16; i++)
            send_text((i < 8) ? low[8*i +: 8] : high[8*(i-8) +: 8], i == 15);
        settle();
    endtask

    // Random patterns over a small alphabet, texts built mostly from pattern prefixes.
    task automatic test_random_streams();
        logic [7:0]  sym [3];
        logic [7:0]  pat [PATTERN_BYTES];
        logic [7:0]  chunk [$];
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] len_data;
        int unsigned eff;
        int unsigned phase;
        int unsigned n;
        int unsigned i;
        int unsigned m;
        int unsigned r;
        for (phase = 0; phase < 12; phase++)
        begin
            for (i = 0; i < 3; i++)
                sym[i] = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 12)
                eff = 16;
            else if (r < 22)
                eff = 1;
            else
                eff = $urandom_range(2, 7);
            for (i = 0; i < PATTERN_BYTES; i++)
                pat[i] = sym[$urandom_range(0, 1)];
            for (i = 0; i < 8; i++)
            begin
                low[8*i +: 8]  = pat[i];
                high[8*i +: 8] = pat[i+8];
            end
            len_data = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            if (eff == 1 && r < 40)
                len_data[4:0] = 5'd0;
            else if (eff == 16 && r < 40)
                len_data[4:0] = 5'($urandom_range(17, 31));
            else
                len_data[4:0] = 5'(eff);

            settle();
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(CFG_UNUSED, (1 << CFG_INDEX_BITS) - 1)),
                          {$urandom, $urandom});
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_PATTERN_LOW, low);
                write_reg(CFG_PATTERN_HIGH, high);
                write_reg(CFG_PATTERN_LENGTH, len_data);
            end
            else
            begin
                write_reg(CFG_PATTERN_LENGTH, len_data);
                write_reg(CFG_PATTERN_HIGH, high);
                write_reg(CFG_PATTERN_LOW, low);
            end

            chunk.delete();
            for (n = 0; n < 140; n++)
            begin
                if (chunk.size() == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                    begin
                        m = (r < 35) ? eff : $urandom_range(1, eff);
                        for (i = 0; i < m; i++)
                            chunk = {chunk, pat[i]};
                    end
                    else if (r < 85)
                        chunk = {chunk, sym[$urandom_range(0, 2)]};
                    else
                        chunk = {chunk, 8'($urandom_range(0, 255))};
                end
                send_text(chunk.pop_front(), $urandom_range(0, 39) == 0);
            end
        end
        settle();
    endtask

    // The result side holds off while text keeps coming, so the input must stall.
    task automatic test_backpressure();
        logic [63:0] low;
        int i;
        low = {$urandom, $urandom};
        write_reg(CFG_PATTERN_LOW, low);
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        send_calm    = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            send_text(low[8*$urandom_range(0, 2) +: 8], $urandom_range(0, 15) == 0);
        send_calm = 1'b0;
        settle();
    endtask

    // Back-to-back words with no stall on either side.
    task automatic test_full_rate();
        logic [63:0] low;
        int i;
        low = {$urandom, $urandom};
        write_reg(CFG_PATTERN_LOW, low);
        write_reg(CFG_PATTERN_LENGTH, 64'd3);
        send_calm = 1'b1;
        recv_calm = 1'b1;
        for (i = 0; i < 150; i++)
            send_text(low[8*$urandom_range(0, 3) +: 8], $urandom_range(0, 29) == 0);
        settle();
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        text_valid   = 1'b0;
        text_word    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        hold_request = 1'b0;
        reset_matcher();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_pattern();
        test_overlap();
        test_length_limits();
        test_random_streams();
        test_backpressure();
        test_full_rate();

        settle();
        repeat (10) @(posedge clk);
        if (predicted_results.size() != 0)
            report_mismatch("result words never delivered",
                            64'(predicted_results.size()), 64'd0);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
